FILE: rtl/keypad_scan_debouncer_unit_macros.svh
// assertion macros for the keypad scan debouncer
// expects clk and rst_n in the scope where a macro is used
`ifndef KEYPAD_SCAN_DEBOUNCER_UNIT_MACROS_SVH
`define KEYPAD_SCAN_DEBOUNCER_UNIT_MACROS_SVH

// same-cycle implication, skipped during reset
`define KSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, skipped during reset
`define KSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ksd_pkg.sv
// shared types and constants for the keypad scan debouncer
// no dependencies
package ksd_pkg;

  // key code meaning no key pressed
  localparam logic [7:0] NO_CODE = 8'hFF;
  // reset value of the stable tick setting
  localparam logic [7:0] STABLE_TICKS_RST = 8'd4;
  // lowest and highest valid key codes
  localparam logic [7:0] KEY_MIN = 8'd5;
  localparam logic [7:0] KEY_MAX = 8'd12;

  // codes per column, index is the row number
  localparam logic [7:0] COL0_CODES [4] = '{8'd5, 8'd6, 8'd7, 8'd8};
  localparam logic [7:0] COL1_CODES [4] = '{8'd12, 8'd11, 8'd10, 8'd9};

  // one scan snapshot, active-low rows
  typedef struct packed {
    logic [3:0] rows_col_zero;
    logic [3:0] rows_col_one;
  } in_req_t;

  // one debounce result
  typedef struct packed {
    logic [7:0] accepted_key;
    logic       new_key;
  } out_req_t;

  // fixed priority encode: column one over column zero, high row over low row
  function automatic logic [7:0] encode_rows(input logic [3:0] c0, input logic [3:0] c1);
    logic [7:0] code;
    code = NO_CODE;
    for (int r = 0; r < 4; r++) begin
      if (!c0[r]) code = COL0_CODES[r];
    end
    for (int r = 0; r < 4; r++) begin
      if (!c1[r]) code = COL1_CODES[r];
    end
    return code;
  endfunction

endpackage

FILE: rtl/keypad_scan_debouncer_unit.sv
// Keypad scan debouncer: each request passes the input register, then encode
// and debounce into the result register.
// Throughput one request per cycle unless out_stall holds the pipeline; set by the single debounce state update.
// Synchronous active-low reset: pipeline empty, stable ticks 4, previous code
// no key, count 0, latched key 0.
// Depends on ksd_pkg and keypad_scan_debouncer_unit_macros.svh.
`include "keypad_scan_debouncer_unit_macros.svh"

module keypad_scan_debouncer_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  ksd_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ksd_pkg::out_req_t out_data
);
  import ksd_pkg::*;

  logic       in_valid_r;
  in_req_t    in_r;
  logic       out_valid_r;
  out_req_t   out_r;
  logic [7:0] stable_ticks_r;
  logic [7:0] prev_code_r, prev_code_nxt;
  logic [7:0] stable_count_r, stable_count_nxt;
  logic [7:0] latched_key_r, latched_key_nxt;
  logic       fresh;
  logic [7:0] code;
  logic       advance;
  logic       hold_hit;

  // pipeline flow control
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !advance;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_ticks_r <= STABLE_TICKS_RST;
    end else if (cfg_we) begin
      stable_ticks_r <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_r <= in_data;
    end
  end

  // encode and debounce
  assign code     = encode_rows(in_r.rows_col_zero, in_r.rows_col_one);
  assign hold_hit = ({1'b0, stable_count_r} == ({1'b0, stable_ticks_r} + 9'd1));

  always_comb begin
    prev_code_nxt    = prev_code_r;
    stable_count_nxt = stable_count_r;
    latched_key_nxt  = latched_key_r;
    fresh            = 1'b0;
    priority if (code == NO_CODE) begin
      prev_code_nxt    = NO_CODE;
      stable_count_nxt = 8'd0;
    end else if (stable_count_r == 8'd0) begin
      prev_code_nxt    = code;
      stable_count_nxt = 8'd1;
    end else if (code != prev_code_r) begin
      prev_code_nxt    = NO_CODE;
      stable_count_nxt = 8'd0;
    end else if (stable_count_r == stable_ticks_r) begin
      latched_key_nxt  = code;
      fresh            = 1'b1;
      stable_count_nxt = stable_count_r + 8'd1;
    end else if (hold_hit) begin
      // already accepted for this press
    end else begin
      stable_count_nxt = stable_count_r + 8'd1;
    end
  end

  // debounce state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_code_r    <= NO_CODE;
      stable_count_r <= 8'd0;
      latched_key_r  <= 8'd0;
      out_valid_r    <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
      if (in_valid_r) begin
        prev_code_r    <= prev_code_nxt;
        stable_count_r <= stable_count_nxt;
        latched_key_r  <= latched_key_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      out_r.accepted_key <= latched_key_nxt;
      out_r.new_key      <= fresh;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  `KSD_ASSERT_NOW(a_new_key_code, out_valid_r && out_r.new_key, (out_r.accepted_key >= KEY_MIN) && (out_r.accepted_key <= KEY_MAX), "new key with invalid code")
  `KSD_ASSERT_NEXT(a_count_after_latch, advance && in_valid_r && fresh, stable_count_r == 8'($past(stable_ticks_r) + 8'd1), "count not past threshold after latch")
  `KSD_ASSERT_NOW(a_stall_needs_item, !in_valid_r, !in_stall, "stall with empty input register")

endmodule
